/* src/assert_macros.svh */
// assertion macros shared by the rtl
// no dependencies; clock clk and reset rst_n are assumed in the user scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define EOG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define EOG_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define EOG_ASSERT(label, prop, msg)
`define EOG_NEVER(label, cond, msg)
`endif
`endif

/* src/eog_pkg.sv */
// shared constants, codes, memory command types and helper functions
// no dependencies
package eog_pkg;

    localparam int MAX_EVENTS = 64;
    localparam int IDX_W      = $clog2(MAX_EVENTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int CODE_W     = 8;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_QUERY  = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    localparam logic [2:0] STAT_OK         = 3'd0;
    localparam logic [2:0] STAT_DESIRED    = 3'd1;
    localparam logic [2:0] STAT_CONFLICT   = 3'd2;
    localparam logic [2:0] STAT_CONCURRENT = 3'd3;
    localparam logic [2:0] STAT_UNKNOWN    = 3'd4;
    localparam logic [2:0] STAT_FULL       = 3'd5;
    localparam logic [2:0] STAT_SAME       = 3'd6;

    typedef struct packed {
        logic              re;
        logic              we;
        logic [IDX_W-1:0]  addr;
        logic [CODE_W-1:0] wdata;
    } code_cmd_t;

    typedef struct packed {
        logic                  re;
        logic                  we;
        logic [IDX_W-1:0]      addr;
        logic [MAX_EVENTS-1:0] wdata;
    } row_cmd_t;

    function automatic logic [MAX_EVENTS-1:0] onehot_of(input logic [IDX_W-1:0] idx);
        logic [MAX_EVENTS-1:0] r;
        r = '0;
        r[idx] = 1'b1;
        return r;
    endfunction

    // lowest set bit of a node mask
    function automatic logic [IDX_W-1:0] lowest_of(input logic [MAX_EVENTS-1:0] v);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int i = MAX_EVENTS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = IDX_W'(i);
            end
        end
        return r;
    endfunction

endpackage

/* src/eog_code_mem.sv */
// event code store, one write and one read per cycle, registered read data
// depends on eog_pkg
module eog_code_mem (
    input  logic                       clk,
    input  eog_pkg::code_cmd_t         cmd,
    output logic [eog_pkg::CODE_W-1:0] rdata
);

    logic [eog_pkg::CODE_W-1:0] mem [eog_pkg::MAX_EVENTS];

    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            mem[cmd.addr] <= cmd.wdata;
        end
        if (cmd.re)
        begin
            rdata <= mem[cmd.addr];
        end
    end

endmodule

/* src/eog_row_mem.sv */
// successor row store, one row per event, registered read data
// depends on eog_pkg
module eog_row_mem (
    input  logic                           clk,
    input  eog_pkg::row_cmd_t              cmd,
    output logic [eog_pkg::MAX_EVENTS-1:0] rdata
);

    logic [eog_pkg::MAX_EVENTS-1:0] mem [eog_pkg::MAX_EVENTS];

    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            mem[cmd.addr] <= cmd.wdata;
        end
        if (cmd.re)
        begin
            rdata <= mem[cmd.addr];
        end
    end

endmodule

/* src/event_order_graph_top.sv */
// happens-before graph store: clear, same event and unused codes are answered straight
// from idle; other requests run a pipelined code search over the stored events, then up
// to two reach walks that read one successor row per visited node, then, for inserts,
// node add and edge write; one request at a time, busy high from transfer to result on searched requests
// done strobes one cycle and the receiver cannot stall; reset clears the event count
// and control; a row is zeroed when its event is added, so memories need no reset
`include "assert_macros.svh"

module event_order_graph_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] req_type,
    input  logic [7:0] before_event,
    input  logic [7:0] after_event,
    output logic       done,
    output logic [2:0] status
);

    localparam int N  = eog_pkg::MAX_EVENTS;
    localparam int IW = eog_pkg::IDX_W;
    localparam int CW = eog_pkg::CNT_W;

    // one-hot sequencer
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_WPICK = 7'b0000100,
        S_WDATA = 7'b0001000,
        S_ADD   = 7'b0010000,
        S_SETRD = 7'b0100000,
        S_SETWR = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]    req_reg, req_next;
    logic [7:0]    bcode_reg, bcode_next, acode_reg, acode_next;
    logic          bfound_reg, bfound_next, afound_reg, afound_next;
    logic [IW-1:0] bslot_reg, bslot_next, aslot_reg, aslot_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          rdv_reg, rdv_next;
    logic [IW-1:0] rdslot_reg, rdslot_next;
    logic [N-1:0]  pending_reg, pending_next, seen_reg, seen_next;
    logic [IW-1:0] dst_reg, dst_next;
    logic          pass_reg, pass_next;
    logic [2:0]    edge_stat_reg, edge_stat_next;
    logic          done_reg, done_next;
    logic [2:0]    status_reg, status_next;

    eog_pkg::code_cmd_t code_cmd;
    eog_pkg::row_cmd_t  row_cmd;
    logic [7:0]         code_rdata;
    logic [N-1:0]       row_rdata;

    logic          issue;
    logic [1:0]    need;
    logic [CW:0]   fill_sum;
    logic [IW-1:0] pick;

    eog_code_mem u_code_mem (
        .clk   (clk),
        .cmd   (code_cmd),
        .rdata (code_rdata)
    );

    eog_row_mem u_row_mem (
        .clk   (clk),
        .cmd   (row_cmd),
        .rdata (row_rdata)
    );

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign status = status_reg;

    assign issue    = (idx_reg < count_reg);
    assign need     = {1'b0, ~bfound_reg} + {1'b0, ~afound_reg};
    assign fill_sum = (CW + 1)'(count_reg) + (CW + 1)'(need);
    assign pick     = eog_pkg::lowest_of(pending_reg);

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        bcode_next     = bcode_reg;
        acode_next     = acode_reg;
        bfound_next    = bfound_reg;
        afound_next    = afound_reg;
        bslot_next     = bslot_reg;
        aslot_next     = aslot_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        rdv_next       = 1'b0;
        rdslot_next    = rdslot_reg;
        pending_next   = pending_reg;
        seen_next      = seen_reg;
        dst_next       = dst_reg;
        pass_next      = pass_reg;
        edge_stat_next = edge_stat_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        code_cmd       = '0;
        row_cmd        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next    = req_type;
                    bcode_next  = before_event;
                    acode_next  = after_event;
                    bfound_next = 1'b0;
                    afound_next = 1'b0;
                    idx_next    = '0;
                    if (req_type == eog_pkg::REQ_CLEAR)
                    begin
                        count_next  = '0;
                        done_next   = 1'b1;
                        status_next = eog_pkg::STAT_OK;
                    end
                    else if (req_type != eog_pkg::REQ_INSERT &&
                             req_type != eog_pkg::REQ_QUERY)
                    begin
                        done_next   = 1'b1;
                        status_next = eog_pkg::STAT_OK;
                    end
                    else if (before_event == after_event)
                    begin
                        done_next   = 1'b1;
                        status_next = eog_pkg::STAT_SAME;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            // pipelined search: issue one code read a cycle, compare the previous one
            S_SCAN:
            begin
                if (issue)
                begin
                    code_cmd.re = 1'b1;
                    code_cmd.addr = idx_reg[IW-1:0];
                    idx_next    = idx_reg + CW'(1);
                    rdv_next    = 1'b1;
                    rdslot_next = idx_reg[IW-1:0];
                end
                if (rdv_reg)
                begin
                    if (code_rdata == bcode_reg)
                    begin
                        bfound_next = 1'b1;
                        bslot_next  = rdslot_reg;
                    end
                    if (code_rdata == acode_reg)
                    begin
                        afound_next = 1'b1;
                        aslot_next  = rdslot_reg;
                    end
                end
                if (!issue && !rdv_reg)
                begin
                    if (bfound_reg && afound_reg)
                    begin
                        // first walk: before reaches after
                        pending_next = eog_pkg::onehot_of(bslot_reg);
                        seen_next    = eog_pkg::onehot_of(bslot_reg);
                        dst_next     = aslot_reg;
                        pass_next    = 1'b0;
                        state_next   = S_WPICK;
                    end
                    else if (req_reg == eog_pkg::REQ_QUERY)
                    begin
                        done_next   = 1'b1;
                        status_next = eog_pkg::STAT_UNKNOWN;
                        state_next  = S_IDLE;
                    end
                    else if (fill_sum > (CW + 1)'(N))
                    begin
                        done_next   = 1'b1;
                        status_next = eog_pkg::STAT_FULL;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        edge_stat_next = eog_pkg::STAT_OK;
                        state_next     = S_ADD;
                    end
                end
            end

            S_WPICK:
            begin
                if (pending_reg == '0)
                begin
                    if (!pass_reg)
                    begin
                        // second walk: after reaches before
                        pending_next = eog_pkg::onehot_of(aslot_reg);
                        seen_next    = eog_pkg::onehot_of(aslot_reg);
                        dst_next     = bslot_reg;
                        pass_next    = 1'b1;
                    end
                    else if (req_reg == eog_pkg::REQ_INSERT)
                    begin
                        edge_stat_next = eog_pkg::STAT_CONCURRENT;
                        state_next     = S_SETRD;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        status_next = eog_pkg::STAT_CONCURRENT;
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    row_cmd.re   = 1'b1;
                    row_cmd.addr = pick;
                    pending_next = pending_reg & ~eog_pkg::onehot_of(pick);
                    state_next   = S_WDATA;
                end
            end

            S_WDATA:
            begin
                if (row_rdata[dst_reg])
                begin
                    done_next   = 1'b1;
                    status_next = pass_reg ? eog_pkg::STAT_CONFLICT : eog_pkg::STAT_DESIRED;
                    state_next  = S_IDLE;
                end
                else
                begin
                    pending_next = pending_reg | (row_rdata & ~seen_reg);
                    seen_next    = seen_reg | row_rdata;
                    state_next   = S_WPICK;
                end
            end

            // new nodes take the next slot with an empty successor row
            S_ADD:
            begin
                if (!bfound_reg || !afound_reg)
                begin
                    code_cmd.we    = 1'b1;
                    code_cmd.addr  = count_reg[IW-1:0];
                    code_cmd.wdata = bfound_reg ? acode_reg : bcode_reg;
                    row_cmd.we     = 1'b1;
                    row_cmd.addr   = count_reg[IW-1:0];
                    row_cmd.wdata  = '0;
                    count_next     = count_reg + CW'(1);
                    if (!bfound_reg)
                    begin
                        bfound_next = 1'b1;
                        bslot_next  = count_reg[IW-1:0];
                    end
                    else
                    begin
                        afound_next = 1'b1;
                        aslot_next  = count_reg[IW-1:0];
                    end
                end
                else
                begin
                    state_next = S_SETRD;
                end
            end

            S_SETRD:
            begin
                row_cmd.re   = 1'b1;
                row_cmd.addr = bslot_reg;
                state_next   = S_SETWR;
            end

            S_SETWR:
            begin
                row_cmd.we    = 1'b1;
                row_cmd.addr  = bslot_reg;
                row_cmd.wdata = row_rdata | eog_pkg::onehot_of(aslot_reg);
                done_next     = 1'b1;
                status_next   = edge_stat_reg;
                state_next    = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            rdv_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rdv_reg   <= rdv_next;
            done_reg  <= done_next;
        end
    end

    // payload and walk registers
    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        bcode_reg     <= bcode_next;
        acode_reg     <= acode_next;
        bfound_reg    <= bfound_next;
        afound_reg    <= afound_next;
        bslot_reg     <= bslot_next;
        aslot_reg     <= aslot_next;
        idx_reg       <= idx_next;
        rdslot_reg    <= rdslot_next;
        pending_reg   <= pending_next;
        seen_reg      <= seen_next;
        dst_reg       <= dst_next;
        pass_reg      <= pass_next;
        edge_stat_reg <= edge_stat_next;
        status_reg    <= status_next;
    end

    // checks
    `EOG_NEVER(a_done_idle, done && busy, "result strobe while busy")
    `EOG_NEVER(a_count_range, count_reg > CW'(N), "event count beyond table")
    `EOG_ASSERT(a_clear_ok, start && !busy && req_type == eog_pkg::REQ_CLEAR |=> done && status == eog_pkg::STAT_OK && count_reg == '0, "clear not answered at once")
    `EOG_ASSERT(a_accept_moves, start && !busy |=> done || busy, "transfer lost")

endmodule

/* dv/tb_top.sv */
// testbench for event_order_graph_top: directed and random insert/query/clear requests
// depends on eog_pkg and the rtl top; predicts each status with its own graph model
`timescale 1ns / 1ps

module tb_top;

    localparam logic [1:0] REQ_UNDEF = 2'd3;

    // happens-before graph predictor and the queue of statuses still owed
    class order_scoreboard;
        logic [7:0]                     codes[eog_pkg::MAX_EVENTS];
        int                             count;
        logic [eog_pkg::MAX_EVENTS-1:0] succ[eog_pkg::MAX_EVENTS];
        logic [2:0]                     owed_status[$];
        int                             errors;

        function new();
            count  = 0;
            errors = 0;
            foreach (succ[i]) succ[i] = '0;
        endfunction

        function int slot_of(logic [7:0] code);
            for (int i = 0; i < count; i++)
            begin
                if (codes[i] == code) return i;
            end
            return -1;
        endfunction

        // transitive closure by mask growth from src
        function bit reaches(int src, int dst);
            logic [eog_pkg::MAX_EVENTS-1:0] seen, grown;
            seen = succ[src];
            do
            begin
                grown = seen;
                for (int i = 0; i < count; i++)
                begin
                    if (seen[i]) grown |= succ[i];
                end
                if (grown == seen) break;
                seen = grown;
            end while (1);
            return seen[dst];
        endfunction

        function logic [2:0] relate(int b, int a);
            if (reaches(b, a)) return eog_pkg::STAT_DESIRED;
            if (reaches(a, b)) return eog_pkg::STAT_CONFLICT;
            return eog_pkg::STAT_CONCURRENT;
        endfunction

        function int add_node(logic [7:0] code);
            codes[count] = code;
            succ[count]  = '0;
            for (int j = 0; j < eog_pkg::MAX_EVENTS; j++) succ[j][count] = 1'b0;
            count++;
            return count - 1;
        endfunction

        function void note_request(logic [1:0] req, logic [7:0] bcode, logic [7:0] acode);
            logic [2:0] st;
            int bs, as_, need;
            st = eog_pkg::STAT_OK;
            if (req == eog_pkg::REQ_CLEAR)
            begin
                count = 0;
                foreach (succ[i]) succ[i] = '0;
            end
            else if (req == eog_pkg::REQ_INSERT || req == eog_pkg::REQ_QUERY)
            begin
                if (bcode == acode) st = eog_pkg::STAT_SAME;
                else
                begin
                    bs  = slot_of(bcode);
                    as_ = slot_of(acode);
                    if (req == eog_pkg::REQ_QUERY)
                        st = (bs < 0 || as_ < 0) ? eog_pkg::STAT_UNKNOWN : relate(bs, as_);
                    else if (bs >= 0 && as_ >= 0)
                    begin
                        st = relate(bs, as_);
                        if (st == eog_pkg::STAT_CONCURRENT) succ[bs][as_] = 1'b1;
                    end
                    else
                    begin
                        need = int'(bs < 0) + int'(as_ < 0);
                        if (count + need > eog_pkg::MAX_EVENTS) st = eog_pkg::STAT_FULL;
                        else
                        begin
                            if (bs < 0) bs = add_node(bcode);
                            if (as_ < 0) as_ = add_node(acode);
                            succ[bs][as_] = 1'b1;
                        end
                    end
                end
            end
            owed_status.push_back(st);
        endfunction

        function void check_status(logic [2:0] got);
            logic [2:0] want;
            if (owed_status.size() == 0)
            begin
                $error("status %0d arrived with nothing expected", got);
                errors++;
                return;
            end
            want = owed_status.pop_front();
            if (got !== want)
            begin
                $error("status mismatch: expected %0d actual %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [1:0] req_type;
    logic [7:0] before_event;
    logic [7:0] after_event;
    logic       done;
    logic [2:0] status;

    order_scoreboard sb;
    int send_idle_pct;
    logic [7:0] pool[16];

    event_order_graph_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .before_event (before_event),
        .after_event  (after_event),
        .done         (done),
        .status       (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // results cannot be held off, so every done strobe is checked as it comes
    always @(posedge clk)
    begin
        if (rst_n && done) sb.check_status(status);
    end

    // one request transfer; random idle cycles ahead of it per the current phase
    // start stays high from one transfer into the next when no idling is drawn
    task automatic send_request(logic [1:0] req, logic [7:0] bcode, logic [7:0] acode);
        int idle_n;
        idle_n = 0;
        while ($urandom_range(99) < send_idle_pct) idle_n++;
        if (idle_n > 0)
        begin
            start        <= 1'b0;
            req_type     <= 2'($urandom_range(3));
            before_event <= 8'($urandom_range(255));
            after_event  <= 8'($urandom_range(255));
            repeat (idle_n) @(posedge clk);
        end
        start        <= 1'b1;
        req_type     <= req;
        before_event <= bcode;
        after_event  <= acode;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_request(req, bcode, acode);
    endtask

    // mostly well-formed inserts and queries over a small code pool so the graph grows deep
    task automatic send_random();
        int roll;
        logic [7:0] b, a;
        roll = $urandom_range(99);
        b = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : pool[$urandom_range(15)];
        a = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : pool[$urandom_range(15)];
        if (roll < 2) send_request(eog_pkg::REQ_CLEAR, b, a);
        else if (roll < 4) send_request(REQ_UNDEF, b, a);
        else if (roll < 45) send_request(eog_pkg::REQ_INSERT, b, a);
        else send_request(eog_pkg::REQ_QUERY, b, a);
    endtask

    task automatic refresh_pool();
        foreach (pool[i]) pool[i] = 8'($urandom_range(255));
    endtask

    initial
    begin
        sb            = new();
        send_idle_pct = 0;
        rst_n         = 1'b0;
        start         = 1'b0;
        req_type      = eog_pkg::REQ_INSERT;
        before_event  = '0;
        after_event   = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: unknown, same event, chain, desired/conflict/concurrent, extremes
        send_request(eog_pkg::REQ_QUERY, 8'd0, 8'd255);
        send_request(eog_pkg::REQ_INSERT, 8'd7, 8'd7);
        send_request(eog_pkg::REQ_QUERY, 8'd9, 8'd9);
        send_request(eog_pkg::REQ_INSERT, 8'd0, 8'd255);
        send_request(eog_pkg::REQ_INSERT, 8'd255, 8'h55);
        send_request(eog_pkg::REQ_INSERT, 8'h55, 8'hAA);
        send_request(eog_pkg::REQ_QUERY, 8'd0, 8'hAA);
        send_request(eog_pkg::REQ_QUERY, 8'hAA, 8'd0);
        send_request(eog_pkg::REQ_INSERT, 8'd0, 8'hAA);
        send_request(eog_pkg::REQ_INSERT, 8'hAA, 8'd0);
        send_request(eog_pkg::REQ_INSERT, 8'd1, 8'd2);
        send_request(eog_pkg::REQ_INSERT, 8'd0, 8'd2);
        send_request(eog_pkg::REQ_QUERY, 8'd0, 8'd2);
        send_request(eog_pkg::REQ_QUERY, 8'd1, 8'd3);
        send_request(REQ_UNDEF, 8'd0, 8'd255);
        send_request(eog_pkg::REQ_CLEAR, 8'd0, 8'd0);
        send_request(eog_pkg::REQ_QUERY, 8'd0, 8'd255);
        // full table: 63 nodes in a chain, then two-new and one-new inserts
        for (int i = 0; i < 62; i++) send_request(eog_pkg::REQ_INSERT, 8'(i), 8'(i + 1));
        send_request(eog_pkg::REQ_INSERT, 8'd200, 8'd201);
        send_request(eog_pkg::REQ_INSERT, 8'd62, 8'd200);
        send_request(eog_pkg::REQ_INSERT, 8'd62, 8'd201);
        send_request(eog_pkg::REQ_INSERT, 8'd0, 8'd62);
        send_request(eog_pkg::REQ_QUERY, 8'd62, 8'd0);
        send_request(eog_pkg::REQ_CLEAR, 8'd0, 8'd0);

        // random phases: no idling, two of heavy sender idling, then light idling
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 2) ? 69 : ((ph == 3) ? 19 : 0);
            for (int n = 0; n < 275; n++)
            begin
                if (n % 60 == 0) refresh_pool();
                send_random();
            end
        end
        start <= 1'b0;

        while (sb.owed_status.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        if (sb.errors == 0 && sb.owed_status.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // guard: ~1200 requests at their worst search plus idling, well covered
    initial
    begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
